FILE: sv/mixture_property_interpolator_defines.svh
// Assertion macros used by the interpolator to check its own logic.
`ifndef MIXTURE_PROPERTY_INTERPOLATOR_DEFINES_SVH
`define MIXTURE_PROPERTY_INTERPOLATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MPI_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define MPI_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/mpi_pkg.sv
package mpi_pkg;

    // Table geometry.
    localparam int MAX_POINTS_DEF = 16;
    localparam int NUM_MATERIALS  = 2;
    localparam int NUM_PROPERTIES = 7;
    localparam int NUM_TABLES     = NUM_MATERIALS * NUM_PROPERTIES;

    // Field widths.
    localparam int TEMP_W = 32;
    localparam int VAL_W  = 48;
    localparam int FRAC_W = 17;
    localparam int IDX_W  = 4;
    localparam int SEL_W  = 3;
    localparam int STAT_W = 2;
    localparam int SAT_IN_W = 52;

    // Multiply-divide unit operand width and quotient cap (two to the 49th).
    localparam int MD_W = 50;
    localparam logic [MD_W-1:0] QUOT_CAP = 50'h2_0000_0000_0000;

    localparam logic [FRAC_W-1:0] ONE_Q16 = 17'h10000;

    // Item kinds.
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Property selectors.
    localparam logic [SEL_W-1:0] PROP_DENSITY   = 3'd0;
    localparam logic [SEL_W-1:0] PROP_SPEC_HEAT = 3'd2;
    localparam logic [SEL_W-1:0] PROP_ENTHALPY  = 3'd5;
    localparam logic [SEL_W-1:0] PROP_LAST      = 3'd6;

    // Status codes.
    localparam logic [STAT_W-1:0] STATUS_OK           = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_ZERO_DENSITY = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_CP_NONPOS    = 2'd2;

    typedef struct packed {
        logic                     kind;
        logic                     material_slot;
        logic [SEL_W-1:0]         property_sel;
        logic [IDX_W-1:0]         point_index;
        logic signed [TEMP_W-1:0] breakpoint_temp;
        logic signed [VAL_W-1:0]  table_value;
        logic                     last_point;
        logic signed [TEMP_W-1:0] temperature;
        logic [FRAC_W-1:0]        volume_fraction;
        logic signed [VAL_W-1:0]  latent_term;
    } t_in_item;

    typedef struct packed {
        logic signed [VAL_W-1:0] density_out;
        logic signed [VAL_W-1:0] conductivity_out;
        logic signed [VAL_W-1:0] specific_heat_out;
        logic signed [VAL_W-1:0] expansion_out;
        logic signed [VAL_W-1:0] resistivity_out;
        logic signed [VAL_W-1:0] enthalpy_out;
        logic signed [VAL_W-1:0] vof_property_out;
        logic [STAT_W-1:0]       status;
    } t_out_item;

    // Saturate a wide signed value to the 48-bit range.
    function automatic logic signed [VAL_W-1:0] sat48(input logic signed [SAT_IN_W-1:0] x);
        logic signed [VAL_W-1:0] r;
        if ((&x[SAT_IN_W-1:VAL_W-1]) || !(|x[SAT_IN_W-1:VAL_W-1])) begin
            r = x[VAL_W-1:0];
        end else if (x[SAT_IN_W-1]) begin
            r = {1'b1, {(VAL_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(VAL_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

FILE: sv/mpi_ram.sv
module mpi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 224
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

FILE: sv/mpi_muldiv.sv
module mpi_muldiv (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [mpi_pkg::MD_W-1:0] i_a,
    input  logic [mpi_pkg::MD_W-1:0] i_b,
    input  logic [mpi_pkg::MD_W-1:0] i_d,
    output logic                     o_done,
    output logic [mpi_pkg::MD_W-1:0] o_quot
);

    localparam int W         = mpi_pkg::MD_W;
    localparam int CHUNK     = 16;
    localparam int MUL_STEPS = (W + CHUNK - 1) / CHUNK;
    localparam int BPAD      = MUL_STEPS * CHUNK;
    localparam int CNT_W     = $clog2(W);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_MUL  = 2'd1;
    localparam logic [1:0] PH_CHK  = 2'd2;
    localparam logic [1:0] PH_DIV  = 2'd3;

    logic [1:0]       r_phase;
    logic [CNT_W-1:0] r_cnt;
    logic             r_done;
    logic [W-1:0]     r_a;
    logic [BPAD-1:0]  r_b;
    logic [W-1:0]     r_d;
    logic [2*W-1:0]   r_acc;
    logic [W-1:0]     r_rem;
    logic [W-1:0]     r_q;

    logic [W+CHUNK-1:0] pp;
    logic [W:0]         rem2;
    logic               qbit;

    // One partial product per cycle, high chunk of b first.
    assign pp   = r_a * r_b[BPAD-1 -: CHUNK];
    // Restoring division step: shift in the next numerator bit.
    assign rem2 = {r_rem, r_acc[W-1]};
    assign qbit = (rem2 >= {1'b0, r_d});

    // Control: multiply, overflow check, then, unless it overflows, one quotient bit a cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_phase)
                PH_IDLE: begin
                    if (i_start) begin
                        r_phase <= PH_MUL;
                        r_cnt   <= '0;
                    end
                end
                PH_MUL: begin
                    if (r_cnt == CNT_W'(MUL_STEPS - 1)) begin
                        r_phase <= PH_CHK;
                    end
                    r_cnt <= r_cnt + 1'b1;
                end
                PH_CHK: begin
                    r_cnt <= '0;
                    if (r_acc[2*W-1:W] >= r_d) begin
                        r_phase <= PH_IDLE;
                        r_done  <= 1'b1;
                    end else begin
                        r_phase <= PH_DIV;
                    end
                end
                PH_DIV: begin
                    if (r_cnt == CNT_W'(W - 1)) begin
                        r_phase <= PH_IDLE;
                        r_done  <= 1'b1;
                    end
                    r_cnt <= r_cnt + 1'b1;
                end
                default: begin
                    r_phase <= PH_IDLE;
                end
            endcase
        end
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        case (r_phase)
            PH_IDLE: begin
                if (i_start) begin
                    r_a   <= i_a;
                    r_b   <= BPAD'(i_b);
                    r_d   <= i_d;
                    r_acc <= '0;
                end
            end
            PH_MUL: begin
                r_acc <= (r_acc << CHUNK) + (2*W)'(pp);
                r_b   <= r_b << CHUNK;
            end
            PH_CHK: begin
                // A high half at or above the divisor means a quotient past the cap.
                if (r_acc[2*W-1:W] >= r_d) begin
                    r_q <= mpi_pkg::QUOT_CAP;
                end else begin
                    r_rem <= r_acc[2*W-1:W];
                    r_q   <= '0;
                end
            end
            PH_DIV: begin
                r_rem <= qbit ? W'(rem2 - {1'b0, r_d}) : rem2[W-1:0];
                r_acc <= r_acc << 1;
                r_q   <= {r_q[W-2:0], qbit};
            end
            default: begin
                r_q <= r_q;
            end
        endcase
    end

    assign o_done = r_done;
    assign o_quot = (r_q > mpi_pkg::QUOT_CAP) ? mpi_pkg::QUOT_CAP : r_q;

endmodule

FILE: sv/mixture_property_interpolator.sv
// Mixture property interpolator.
// Input channel (i_in_valid / o_in_stall / i_in_item) carries load items and
// query items. A load item writes one breakpoint of one material table and
// gives no result. A query item gives one result item on the output
// channel (o_out_valid / i_out_stall / o_out_item).
// A query runs its fourteen tables one after another: per table up to
// MAX_POINTS + 2 reads of the breakpoint and value memories (one port each)
// and, inside a segment, one pass of the shared multiply-divide unit; then,
// unless the total density is zero, two mass-weighting divides. One query
// is in work at a time; the next item is taken as soon as the result sits
// in the output register.
// While the receiver stalls, the output register holds its item and the
// input keeps being accepted until a second result is ready.
// Reset empties every table (counts to zero); memory contents stay
// undefined until loaded.
`include "mixture_property_interpolator_defines.svh"

module mixture_property_interpolator #(
    parameter int MAX_POINTS = mpi_pkg::MAX_POINTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  mpi_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output mpi_pkg::t_out_item  o_out_item
);

    localparam int DEPTH = mpi_pkg::NUM_TABLES * MAX_POINTS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW    = $clog2(MAX_POINTS + 1);
    localparam int TBW   = $clog2(mpi_pkg::NUM_TABLES);
    localparam int VW    = mpi_pkg::VAL_W;
    localparam int TW    = mpi_pkg::TEMP_W;
    localparam int FW    = mpi_pkg::FRAC_W;
    localparam int MW    = mpi_pkg::MD_W;
    localparam int SW    = mpi_pkg::SAT_IN_W;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_T_START = 4'd1;
    localparam logic [3:0] S_T_FIRST = 4'd2;
    localparam logic [3:0] S_T_LAST  = 4'd3;
    localparam logic [3:0] S_T_SCAN  = 4'd4;
    localparam logic [3:0] S_T_DIV   = 4'd5;
    localparam logic [3:0] S_WGT     = 4'd6;
    localparam logic [3:0] S_SUM     = 4'd7;
    localparam logic [3:0] S_MIX_CP  = 4'd8;
    localparam logic [3:0] S_CP_DIV  = 4'd9;
    localparam logic [3:0] S_CP_ADD  = 4'd10;
    localparam logic [3:0] S_H_DIV   = 4'd11;
    localparam logic [3:0] S_OUT     = 4'd12;

    logic [3:0]                    r_state;
    logic [CW-1:0]                 r_count [mpi_pkg::NUM_TABLES];
    logic [mpi_pkg::SEL_W-1:0]     r_p;
    logic                          r_m;
    logic [IW-1:0]                 r_idx;
    logic signed [TW-1:0]          r_temp;
    logic [FW-1:0]                 r_w1;
    logic signed [VW-1:0]          r_latent;
    logic signed [TW-1:0]          r_tprev;
    logic signed [VW-1:0]          r_vprev;
    logic                          r_neg;
    logic signed [VW-1:0]          r_val;
    logic signed [MW-1:0]          r_term0;
    logic signed [MW-1:0]          r_term1;
    logic signed [MW-1:0]          r_d0;
    logic signed [MW-1:0]          r_d1;
    logic signed [VW-1:0]          r_cp0;
    logic signed [VW-1:0]          r_cp1;
    logic signed [VW-1:0]          r_h0;
    logic signed [VW-1:0]          r_h1;
    logic signed [VW-1:0]          r_mm;
    logic signed [VW-1:0]          r_res [mpi_pkg::NUM_PROPERTIES];
    logic [mpi_pkg::STAT_W-1:0]    r_status;
    logic                          r_ovalid;
    mpi_pkg::t_out_item            r_out;

    logic                  in_accept;
    logic                  load_we;
    logic [TBW-1:0]        tb_load;
    logic [AW-1:0]         waddr;
    logic [mpi_pkg::IDX_W:0] kp1;
    logic [TBW-1:0]        tb_q;
    logic [CW-1:0]         cnt;
    logic [IW-1:0]         rd_off;
    logic [AW-1:0]         raddr;
    logic [TW-1:0]         bp_raw;
    logic [VW-1:0]         v_raw;
    logic signed [TW-1:0]  bp_rd;
    logic signed [VW-1:0]  v_rd;
    logic [FW-1:0]         f_clamped;

    logic signed [VW:0]    dv;
    logic [MW-1:0]         dv_mag;
    logic [TW:0]           tnum;
    logic [TW:0]           tden;

    logic [FW-1:0]         w_cur;
    logic [VW-1:0]         val_u;
    logic [VW-1:0]         val_mag;
    logic [VW+FW-1:0]      wprod;
    logic [MW-1:0]         term_mag;
    logic signed [MW-1:0]  term;
    logic signed [MW-1:0]  wsum;

    logic signed [MW-1:0]  total;
    logic [MW-1:0]         tot_mag;
    logic [MW-1:0]         d1_mag;
    logic signed [VW:0]    dp_cp;
    logic signed [VW:0]    dp_h;
    logic [MW-1:0]         dpcp_mag;
    logic [MW-1:0]         dph_mag;
    logic                  neg_cp;
    logic                  neg_h;

    logic                  md_start;
    logic [MW-1:0]         md_a;
    logic [MW-1:0]         md_b;
    logic [MW-1:0]         md_d;
    logic                  md_done;
    logic [MW-1:0]         md_quot;

    logic signed [MW-1:0]  interp_res;
    logic signed [SW-1:0]  mix_cp;
    logic signed [SW-1:0]  mix_h;
    logic signed [SW-1:0]  cp_sum;

    // Handshake: items are taken only while no query is in work.
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_out_valid = r_ovalid;
    assign o_out_item  = r_out;

    // Load address and write enable.
    assign tb_load = TBW'(i_in_item.material_slot) * TBW'(mpi_pkg::NUM_PROPERTIES)
                   + TBW'(i_in_item.property_sel);
    assign waddr   = AW'(tb_load) * AW'(MAX_POINTS) + AW'(i_in_item.point_index);
    assign load_we = in_accept && (i_in_item.kind == mpi_pkg::KIND_LOAD)
                   && (i_in_item.property_sel <= mpi_pkg::PROP_LAST)
                   && (32'(i_in_item.point_index) < 32'(MAX_POINTS));
    assign kp1     = {1'b0, i_in_item.point_index} + 1'b1;

    // Read address: table base plus the point the sequencer wants next.
    assign tb_q = r_m ? (TBW'(r_p) + TBW'(mpi_pkg::NUM_PROPERTIES)) : TBW'(r_p);
    assign cnt  = r_count[tb_q];

    always_comb begin
        case (r_state)
            S_T_FIRST: rd_off = IW'(cnt - CW'(1));
            S_T_LAST:  rd_off = IW'(1);
            S_T_SCAN:  rd_off = r_idx + IW'(1);
            default:   rd_off = '0;
        endcase
    end

    assign raddr = AW'(tb_q) * AW'(MAX_POINTS) + AW'(rd_off);

    mpi_ram #(
        .WIDTH (TW),
        .DEPTH (DEPTH)
    ) u_bp_ram (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr (waddr),
        .i_wdata (i_in_item.breakpoint_temp),
        .i_raddr (raddr),
        .o_rdata (bp_raw)
    );

    mpi_ram #(
        .WIDTH (VW),
        .DEPTH (DEPTH)
    ) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr (waddr),
        .i_wdata (i_in_item.table_value),
        .i_raddr (raddr),
        .o_rdata (v_raw)
    );

    assign bp_rd = $signed(bp_raw);
    assign v_rd  = $signed(v_raw);

    // Fraction above one counts as one.
    assign f_clamped = (i_in_item.volume_fraction > mpi_pkg::ONE_Q16)
                     ? mpi_pkg::ONE_Q16 : i_in_item.volume_fraction;

    // Segment operands: value step, distance into the segment, segment length.
    assign dv     = {v_rd[VW-1], v_rd} - {r_vprev[VW-1], r_vprev};
    assign dv_mag = MW'(dv[VW] ? -dv : dv);
    assign tnum   = {r_temp[TW-1], r_temp} - {r_tprev[TW-1], r_tprev};
    assign tden   = {bp_rd[TW-1], bp_rd} - {r_tprev[TW-1], r_tprev};

    // Volume weight term: sign times floor(|p| * w / 2^16).
    assign w_cur    = r_m ? r_w1 : (mpi_pkg::ONE_Q16 - r_w1);
    assign val_u    = r_val;
    assign val_mag  = r_val[VW-1] ? -val_u : val_u;
    assign wprod    = val_mag * w_cur;
    assign term_mag = MW'(wprod[VW+FW-1:16]);
    assign term     = r_val[VW-1] ? -$signed(term_mag) : $signed(term_mag);
    assign wsum     = r_term0 + r_term1;

    // Mass weighting operands.
    assign total    = r_d0 + r_d1;
    assign tot_mag  = total[MW-1] ? -total : total;
    assign d1_mag   = r_d1[MW-1] ? -r_d1 : r_d1;
    assign dp_cp    = {r_cp1[VW-1], r_cp1} - {r_cp0[VW-1], r_cp0};
    assign dp_h     = {r_h1[VW-1], r_h1} - {r_h0[VW-1], r_h0};
    assign dpcp_mag = MW'(dp_cp[VW] ? -dp_cp : dp_cp);
    assign dph_mag  = MW'(dp_h[VW] ? -dp_h : dp_h);
    assign neg_cp   = r_d1[MW-1] ^ dp_cp[VW] ^ total[MW-1];
    assign neg_h    = r_d1[MW-1] ^ dp_h[VW] ^ total[MW-1];

    // Multiply-divide unit requests.
    always_comb begin
        md_start = 1'b0;
        md_a     = dv_mag;
        md_b     = MW'(tnum);
        md_d     = MW'(tden);
        case (r_state)
            S_T_SCAN: begin
                md_start = (r_temp <= bp_rd);
            end
            S_MIX_CP: begin
                md_start = (total != '0);
                md_a     = d1_mag;
                md_b     = dpcp_mag;
                md_d     = tot_mag;
            end
            S_CP_ADD: begin
                md_start = 1'b1;
                md_a     = d1_mag;
                md_b     = dph_mag;
                md_d     = tot_mag;
            end
            default: begin
                md_start = 1'b0;
            end
        endcase
    end

    mpi_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (md_start),
        .i_a     (md_a),
        .i_b     (md_b),
        .i_d     (md_d),
        .o_done  (md_done),
        .o_quot  (md_quot)
    );

    // Results of the divides.
    assign interp_res = r_neg ? ({{(MW-VW){r_vprev[VW-1]}}, r_vprev} - $signed(md_quot))
                              : ({{(MW-VW){r_vprev[VW-1]}}, r_vprev} + $signed(md_quot));
    assign mix_cp = neg_cp ? ({{(SW-VW){r_cp0[VW-1]}}, r_cp0} - $signed(SW'(md_quot)))
                           : ({{(SW-VW){r_cp0[VW-1]}}, r_cp0} + $signed(SW'(md_quot)));
    assign mix_h  = neg_h ? ({{(SW-VW){r_h0[VW-1]}}, r_h0} - $signed(SW'(md_quot)))
                          : ({{(SW-VW){r_h0[VW-1]}}, r_h0} + $signed(SW'(md_quot)));
    assign cp_sum = {{(SW-VW){r_mm[VW-1]}}, r_mm} + {{(SW-VW){r_latent[VW-1]}}, r_latent};

    // Control state, counts and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            for (int t = 0; t < mpi_pkg::NUM_TABLES; t++) begin
                r_count[t] <= '0;
            end
        end else begin
            // The result leaves unless a new one replaces it this cycle.
            if (r_ovalid && !i_out_stall && (r_state != S_OUT)) begin
                r_ovalid <= 1'b0;
            end
            if (load_we && i_in_item.last_point) begin
                r_count[tb_load] <= CW'(kp1);
            end
            case (r_state)
                S_IDLE: begin
                    if (in_accept && (i_in_item.kind == mpi_pkg::KIND_QUERY)) begin
                        r_state <= S_T_START;
                    end
                end
                S_T_START: begin
                    r_state <= (cnt == '0) ? S_WGT : S_T_FIRST;
                end
                S_T_FIRST: begin
                    if ((cnt == CW'(1)) || (r_temp <= bp_rd)) begin
                        r_state <= S_WGT;
                    end else begin
                        r_state <= S_T_LAST;
                    end
                end
                S_T_LAST: begin
                    r_state <= (r_temp >= bp_rd) ? S_WGT : S_T_SCAN;
                end
                S_T_SCAN: begin
                    if (r_temp <= bp_rd) begin
                        r_state <= S_T_DIV;
                    end
                end
                S_T_DIV: begin
                    if (md_done) begin
                        r_state <= S_WGT;
                    end
                end
                S_WGT: begin
                    r_state <= r_m ? S_SUM : S_T_START;
                end
                S_SUM: begin
                    r_state <= (r_p == mpi_pkg::PROP_LAST) ? S_MIX_CP : S_T_START;
                end
                S_MIX_CP: begin
                    r_state <= (total == '0) ? S_OUT : S_CP_DIV;
                end
                S_CP_DIV: begin
                    if (md_done) begin
                        r_state <= S_CP_ADD;
                    end
                end
                S_CP_ADD: begin
                    r_state <= S_H_DIV;
                end
                S_H_DIV: begin
                    if (md_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || !i_out_stall) begin
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers of the query sequencer.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    r_temp   <= i_in_item.temperature;
                    r_w1     <= f_clamped;
                    r_latent <= i_in_item.latent_term;
                    r_p      <= mpi_pkg::PROP_DENSITY;
                    r_m      <= 1'b0;
                end
            end
            S_T_START: begin
                if (cnt == '0) begin
                    r_val <= '0;
                end
            end
            S_T_FIRST: begin
                r_val   <= v_rd;
                r_tprev <= bp_rd;
                r_vprev <= v_rd;
            end
            S_T_LAST: begin
                r_val <= v_rd;
                r_idx <= IW'(1);
            end
            S_T_SCAN: begin
                if (r_temp <= bp_rd) begin
                    r_neg <= dv[VW];
                end else begin
                    r_tprev <= bp_rd;
                    r_vprev <= v_rd;
                    r_idx   <= r_idx + IW'(1);
                end
            end
            S_T_DIV: begin
                if (md_done) begin
                    r_val <= interp_res[VW-1:0];
                end
            end
            S_WGT: begin
                if (r_m) begin
                    r_term1 <= term;
                    if (r_p == mpi_pkg::PROP_SPEC_HEAT) begin
                        r_cp1 <= r_val;
                    end
                    if (r_p == mpi_pkg::PROP_ENTHALPY) begin
                        r_h1 <= r_val;
                    end
                end else begin
                    r_term0 <= term;
                    r_m     <= 1'b1;
                    if (r_p == mpi_pkg::PROP_SPEC_HEAT) begin
                        r_cp0 <= r_val;
                    end
                    if (r_p == mpi_pkg::PROP_ENTHALPY) begin
                        r_h0 <= r_val;
                    end
                end
            end
            S_SUM: begin
                r_res[r_p] <= mpi_pkg::sat48({{(SW-MW){wsum[MW-1]}}, wsum});
                if (r_p == mpi_pkg::PROP_DENSITY) begin
                    r_d0 <= r_term0;
                    r_d1 <= r_term1;
                end
                r_p <= r_p + 1'b1;
                r_m <= 1'b0;
            end
            S_MIX_CP: begin
                // Zero total density leaves no mass weights.
                if (total == '0) begin
                    r_status                          <= mpi_pkg::STATUS_ZERO_DENSITY;
                    r_res[mpi_pkg::PROP_SPEC_HEAT]    <= '0;
                    r_res[mpi_pkg::PROP_ENTHALPY]     <= '0;
                end
            end
            S_CP_DIV: begin
                if (md_done) begin
                    r_mm <= mpi_pkg::sat48(mix_cp);
                end
            end
            S_CP_ADD: begin
                r_res[mpi_pkg::PROP_SPEC_HEAT] <= mpi_pkg::sat48(cp_sum);
            end
            S_H_DIV: begin
                if (md_done) begin
                    r_res[mpi_pkg::PROP_ENTHALPY] <= mpi_pkg::sat48(mix_h);
                    r_status <= (r_res[mpi_pkg::PROP_SPEC_HEAT] <= 0)
                              ? mpi_pkg::STATUS_CP_NONPOS : mpi_pkg::STATUS_OK;
                end
            end
            S_OUT: begin
                if (!r_ovalid || !i_out_stall) begin
                    r_out.density_out       <= r_res[0];
                    r_out.conductivity_out  <= r_res[1];
                    r_out.specific_heat_out <= r_res[2];
                    r_out.expansion_out     <= r_res[3];
                    r_out.resistivity_out   <= r_res[4];
                    r_out.enthalpy_out      <= r_res[5];
                    r_out.vof_property_out  <= r_res[6];
                    r_out.status            <= r_status;
                end
            end
            default: begin
                r_val <= r_val;
            end
        endcase
    end

    // The scan never compares past the table's last loaded point.
    `MPI_ASSERT_IMP(a_scan_in_table, i_clk, i_rst_n, r_state == S_T_SCAN, (CW+1)'(r_idx) < (CW+1)'(cnt), "segment scan ran past the table end")
    // The divide unit only finishes while the sequencer waits for it.
    `MPI_ASSERT_IMP(a_div_done_waited, i_clk, i_rst_n, md_done, r_state == S_T_DIV || r_state == S_CP_DIV || r_state == S_H_DIV, "divide finished with no waiting state")
    // An accepted query starts with the first table.
    `MPI_ASSERT_NXT(a_query_starts, i_clk, i_rst_n, in_accept && i_in_item.kind == mpi_pkg::KIND_QUERY, r_state == S_T_START && r_p == mpi_pkg::PROP_DENSITY && !r_m, "query did not start at the first table")
    // A result item appears only when a query finishes.
    `MPI_ASSERT_IMP(a_result_from_query, i_clk, i_rst_n, $rose(o_out_valid), $past(r_state) == S_OUT, "result item without a finished query")

endmodule

FILE: bench/tb_mixture_property_interpolator.sv
`timescale 1ns / 100ps

module tb_mixture_property_interpolator;
    import mpi_pkg::*;

    localparam int NPTS = MAX_POINTS_DEF;
    localparam int RANDOM_ITEMS = 1500;
    localparam int DRAIN_CYCLES = 2000;
    localparam int HOLD_CYCLES = 6000;
    localparam logic [SEL_W-1:0] PROP_INVALID = 3'd7;
    localparam longint MAX48 = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint MIN48 = -64'sh0000_8000_0000_0000;
    localparam logic [63:0] CAP = 64'h0002_0000_0000_0000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    t_in_item i_in_item = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_out_item o_out_item;

    mixture_property_interpolator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_item(i_in_item),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_item(o_out_item)
    );

    always #1 i_clk = ~i_clk;

    // Shadow copy of the breakpoint tables.
    longint bp_tab [NUM_TABLES][NPTS];
    longint val_tab [NUM_TABLES][NPTS];
    int pts [NUM_TABLES];
    bit written [NUM_TABLES][NPTS];

    t_out_item expected_props[$];
    int errors = 0;
    int results_seen = 0;

    function automatic longint clamp48(input longint v);
        if (v > MAX48) return MAX48;
        if (v < MIN48) return MIN48;
        return v;
    endfunction

    function automatic logic [63:0] magnitude(input longint v);
        return v < 0 ? 64'd0 - 64'(v) : 64'(v);
    endfunction

    // floor(a*b/d) capped at two to the 49th.
    function automatic logic [63:0] scaled_ratio(input logic [63:0] a, b, d);
        logic [127:0] q;
        q = ({64'd0, a} * {64'd0, b}) / {64'd0, d};
        if (q > {64'd0, CAP}) return CAP;
        return q[63:0];
    endfunction

    // Piecewise-linear lookup, clamped to the end values.
    function automatic longint table_lookup(input int tb, input longint t);
        int n;
        longint t1, t2, v1, dv;
        logic [63:0] inc;
        n = pts[tb];
        if (n == 0) return 0;
        if (n == 1 || t <= bp_tab[tb][0]) return val_tab[tb][0];
        if (t >= bp_tab[tb][n-1]) return val_tab[tb][n-1];
        for (int i = 0; i + 1 < n; i++) begin
            if (t <= bp_tab[tb][i+1]) begin
                t1 = bp_tab[tb][i];
                t2 = bp_tab[tb][i+1];
                v1 = val_tab[tb][i];
                dv = val_tab[tb][i+1] - v1;
                inc = scaled_ratio(magnitude(dv), 64'(t - t1), 64'(t2 - t1));
                return dv < 0 ? v1 - longint'(inc) : v1 + longint'(inc);
            end
        end
        return val_tab[tb][n-1];
    endfunction

    function automatic longint frac_scale(input longint p, input longint w);
        logic [127:0] prod;
        logic [63:0] m;
        prod = {64'd0, magnitude(p)} * 128'(w);
        m = prod[79:16];
        return p < 0 ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint mass_blend(input longint p0, p1, d1, total);
        longint dp;
        bit neg;
        logic [63:0] q;
        dp = p1 - p0;
        neg = ((d1 < 0) != (dp < 0)) != (total < 0);
        q = scaled_ratio(magnitude(d1), magnitude(dp), magnitude(total));
        return clamp48(neg ? p0 - longint'(q) : p0 + longint'(q));
    endfunction

    // Apply one item to the shadow tables; a query yields its property set.
    task automatic apply_item(input t_in_item it, output bit has, output t_out_item r);
        int tb;
        longint t, f, d0, d1, total;
        longint v [2][NUM_PROPERTIES];
        longint res [NUM_PROPERTIES];
        logic [STAT_W-1:0] st;
        has = 1'b0;
        r = '0;
        if (it.kind == KIND_LOAD) begin
            if (it.property_sel != PROP_INVALID) begin
                tb = it.material_slot * NUM_PROPERTIES + it.property_sel;
                bp_tab[tb][it.point_index] = longint'(it.breakpoint_temp);
                val_tab[tb][it.point_index] = longint'(it.table_value);
                written[tb][it.point_index] = 1'b1;
                if (it.last_point) pts[tb] = it.point_index + 1;
            end
        end else begin
            has = 1'b1;
            st = STATUS_OK;
            t = longint'(it.temperature);
            f = longint'(it.volume_fraction);
            if (f > 65536) f = 65536;
            for (int m = 0; m < 2; m++)
                for (int p = 0; p < NUM_PROPERTIES; p++)
                    v[m][p] = table_lookup(m * NUM_PROPERTIES + p, t);
            for (int p = 0; p < NUM_PROPERTIES; p++)
                res[p] = clamp48(frac_scale(v[0][p], 65536 - f) + frac_scale(v[1][p], f));
            d0 = frac_scale(v[0][PROP_DENSITY], 65536 - f);
            d1 = frac_scale(v[1][PROP_DENSITY], f);
            total = d0 + d1;
            if (total == 0) begin
                st = STATUS_ZERO_DENSITY;
                res[PROP_SPEC_HEAT] = 0;
                res[PROP_ENTHALPY] = 0;
            end else begin
                res[PROP_SPEC_HEAT] = clamp48(mass_blend(v[0][PROP_SPEC_HEAT],
                    v[1][PROP_SPEC_HEAT], d1, total) + longint'(it.latent_term));
                res[PROP_ENTHALPY] = mass_blend(v[0][PROP_ENTHALPY],
                    v[1][PROP_ENTHALPY], d1, total);
                if (res[PROP_SPEC_HEAT] <= 0) st = STATUS_CP_NONPOS;
            end
            r.density_out = res[0][VAL_W-1:0];
            r.conductivity_out = res[1][VAL_W-1:0];
            r.specific_heat_out = res[2][VAL_W-1:0];
            r.expansion_out = res[3][VAL_W-1:0];
            r.resistivity_out = res[4][VAL_W-1:0];
            r.enthalpy_out = res[5][VAL_W-1:0];
            r.vof_property_out = res[6][VAL_W-1:0];
            r.status = st;
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 4);
        return $urandom_range(30, 300);
    endfunction

    function automatic longint rand48();
        logic [63:0] x;
        x = {$urandom, $urandom};
        return longint'($signed(x[VAL_W-1:0]));
    endfunction

    function automatic longint rand_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return longint'($urandom_range(0, 1 << 25)) - (1 << 24);
        if (r < 9) return rand48();
        return ($urandom_range(0, 1) != 0) ? MAX48 : MIN48;
    endfunction

    function automatic t_in_item load_item(input int m, p, k, input longint t, v,
                                           input bit last);
        t_in_item it;
        logic [223:0] noise;
        noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        it = noise[$bits(t_in_item)-1:0];
        it.kind = KIND_LOAD;
        it.material_slot = m[0];
        it.property_sel = p[SEL_W-1:0];
        it.point_index = k[IDX_W-1:0];
        it.breakpoint_temp = t[TEMP_W-1:0];
        it.table_value = v[VAL_W-1:0];
        it.last_point = last;
        return it;
    endfunction

    function automatic t_in_item query_item(input longint t, input int f, input longint lat);
        t_in_item it;
        logic [223:0] noise;
        noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        it = noise[$bits(t_in_item)-1:0];
        it.kind = KIND_QUERY;
        it.temperature = t[TEMP_W-1:0];
        it.volume_fraction = f[FRAC_W-1:0];
        it.latent_term = lat[VAL_W-1:0];
        return it;
    endfunction

    // Hand one item to the block and record what it should produce.
    task automatic offer(input t_in_item it, input bit typed, input t_out_item typed_res);
        int gap;
        bit has;
        t_out_item r;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        do @(posedge i_clk); while (o_in_stall);
        apply_item(it, has, r);
        if (has) expected_props.push_back(typed ? typed_res : r);
    endtask

    typedef struct {
        t_in_item item;
        bit typed;
        t_out_item res;
    } t_row;

    t_row directed[$];

    function automatic t_out_item only_density(input longint d, input logic [1:0] st);
        t_out_item r;
        r = '0;
        r.density_out = d[VAL_W-1:0];
        r.status = st;
        return r;
    endfunction

    task automatic add_row(input t_in_item it, input bit typed = 1'b0,
                           input t_out_item res = '0);
        t_row row;
        row.item = it;
        row.typed = typed;
        row.res = res;
        directed.push_back(row);
    endtask

    task automatic check_field(input string nm, input longint e, input longint a);
        if (e != a) begin
            $error("%s: expected %0d, got %0d", nm, e, a);
            errors++;
        end
    endtask

    // Compare each accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        t_out_item e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (expected_props.size() == 0) begin
                $error("result item arrived with no query outstanding");
                errors++;
            end else begin
                e = expected_props.pop_front();
                check_field("density_out", e.density_out, o_out_item.density_out);
                check_field("conductivity_out", e.conductivity_out,
                            o_out_item.conductivity_out);
                check_field("specific_heat_out", e.specific_heat_out,
                            o_out_item.specific_heat_out);
                check_field("expansion_out", e.expansion_out, o_out_item.expansion_out);
                check_field("resistivity_out", e.resistivity_out,
                            o_out_item.resistivity_out);
                check_field("enthalpy_out", e.enthalpy_out, o_out_item.enthalpy_out);
                check_field("vof_property_out", e.vof_property_out,
                            o_out_item.vof_property_out);
                check_field("status", e.status, o_out_item.status);
            end
        end
    end

    // Receiver: random stalls, plus one long hold so the block backs up.
    initial begin
        int len;
        bit held;
        held = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (!held && results_seen >= 10) begin
                held = 1'b1;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            if ($urandom_range(0, 1) != 0) begin
                i_out_stall <= 1'b1;
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 200)
                                                   : $urandom_range(1, 3);
            end else begin
                i_out_stall <= 1'b0;
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400)
                                                  : $urandom_range(1, 40);
            end
            repeat (len) @(posedge i_clk);
        end
    end

    // Run limit.
    initial begin
        #20000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        int sent, r, m, p, n, tb, k;
        longint tcur, tq, lat;
        int f;
        bit ok;
        t_in_item it;
        for (int i = 0; i < NUM_TABLES; i++) begin
            pts[i] = 0;
            for (int j = 0; j < NPTS; j++) written[i][j] = 1'b0;
        end

        // Directed rows.
        add_row(query_item(0, 0, 0), 1'b1, only_density(0, STATUS_ZERO_DENSITY));
        add_row(load_item(0, PROP_DENSITY, 0, 0, 65536, 1'b1));
        add_row(query_item(12345, 0, 0), 1'b1, only_density(65536, STATUS_CP_NONPOS));
        add_row(query_item(0, 65536, 0), 1'b1, only_density(0, STATUS_ZERO_DENSITY));
        // Fraction above one acts as one.
        add_row(query_item(0, 17'h1FFFF, 0), 1'b1, only_density(0, STATUS_ZERO_DENSITY));
        add_row(load_item(1, PROP_DENSITY, 0, -64'sd2147483648, MAX48, 1'b0));
        add_row(load_item(1, PROP_DENSITY, 1, 64'sd2147483647, MIN48, 1'b1));
        add_row(load_item(0, PROP_SPEC_HEAT, 0, -1000, 3 << 16, 1'b1));
        add_row(load_item(1, PROP_SPEC_HEAT, 0, -5000, 1 << 16, 1'b0));
        add_row(load_item(1, PROP_SPEC_HEAT, 1, 5000, 9 << 16, 1'b1));
        add_row(load_item(0, PROP_ENTHALPY, 0, 0, MIN48, 1'b0));
        add_row(load_item(0, PROP_ENTHALPY, 1, 1 << 20, MAX48, 1'b1));
        add_row(query_item(-64'sd2147483648, 32768, 0));
        add_row(query_item(64'sd2147483647, 32768, MAX48));
        add_row(query_item(0, 32768, MIN48));
        add_row(query_item(1 << 19, 17'h1FFFF, 0));
        // A load with the bad selector must leave the tables alone.
        add_row(load_item(0, PROP_INVALID, 3, 77, 88, 1'b1));
        // Unsorted breakpoints.
        add_row(load_item(0, 1, 0, 100, 5, 1'b0));
        add_row(load_item(0, 1, 1, 50, MAX48, 1'b0));
        add_row(load_item(0, 1, 2, 200, -7, 1'b1));
        add_row(query_item(150, 0, 0));
        add_row(query_item(75, 1000, 1 << 16));
        // Negative density.
        add_row(load_item(0, PROP_DENSITY, 0, 0, -65536, 1'b1));
        add_row(query_item(0, 0, 0));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[i]) offer(directed[i].item, directed[i].typed, directed[i].res);

        // Random part: table rebuilds, queries and noise.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 25) begin
                m = $urandom_range(0, 1);
                p = $urandom_range(0, NUM_PROPERTIES - 1);
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, NPTS)
                                                : $urandom_range(1, 4);
                tcur = longint'($urandom_range(0, 1 << 30)) - (1 << 29);
                for (int i = 0; i < n; i++) begin
                    offer(load_item(m, p, i, tcur, rand_value(), i == n - 1), 1'b0, '0);
                    sent++;
                    if ($urandom_range(0, 7) == 0)
                        tcur -= $urandom_range(0, 1 << 22);
                    else
                        tcur += $urandom_range(0, 1 << 24);
                end
            end else if (r < 80) begin
                tb = $urandom_range(0, NUM_TABLES - 1);
                if (pts[tb] > 0 && $urandom_range(0, 4) != 0)
                    tq = bp_tab[tb][$urandom_range(0, pts[tb] - 1)]
                         + longint'($urandom_range(0, 1 << 25)) - (1 << 24);
                else
                    tq = longint'($signed($urandom));
                case ($urandom_range(0, 5))
                    0: f = 0;
                    1: f = 65536;
                    2: f = $urandom_range(65537, 17'h1FFFF);
                    default: f = $urandom_range(0, 65536);
                endcase
                case ($urandom_range(0, 3))
                    0: lat = 0;
                    1: lat = rand48();
                    default: lat = longint'($urandom_range(0, 1 << 20)) - (1 << 19);
                endcase
                offer(query_item(tq, f, lat), 1'b0, '0);
                sent++;
            end else begin
                m = $urandom_range(0, 1);
                p = $urandom_range(0, NUM_PROPERTIES - 1);
                k = $urandom_range(0, NPTS - 1);
                tb = m * NUM_PROPERTIES + p;
                case ($urandom_range(0, 2))
                    0: it = load_item(m, PROP_INVALID, k, longint'($signed($urandom)),
                                      rand48(), $urandom_range(0, 1) != 0);
                    1: it = load_item(m, p, k, longint'($signed($urandom)), rand48(), 1'b0);
                    default: begin
                        // A count may only cover points that already hold data.
                        ok = 1'b1;
                        for (int i = 0; i < k; i++) if (!written[tb][i]) ok = 1'b0;
                        it = load_item(m, p, k, longint'($signed($urandom)),
                                       rand_value(), ok);
                    end
                endcase
                offer(it, 1'b0, '0);
                sent++;
            end
        end
        i_in_valid <= 1'b0;

        while (expected_props.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+sv
sv/mpi_pkg.sv
sv/mpi_ram.sv
sv/mpi_muldiv.sv
sv/mixture_property_interpolator.sv
bench/tb_mixture_property_interpolator.sv
